// File: rtl/core/knn_pkg.sv
// knn_pkg: types and constants shared by the nearest-neighbour search block
// no dependencies
package knn_pkg;

  localparam int unsigned OpBits = 1;

  typedef enum logic [OpBits-1:0] {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  // register addresses (byte address / 4)
  typedef enum logic [0:0] {
    REG_NEIGHBOR_COUNT = 1'b0,
    REG_POINT_COUNT    = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_SCAN = 2'd1,
    ST_DRAIN = 2'd2,
    ST_EMIT = 2'd3
  } back_state_t;

endpackage

// File: rtl/core/knn_stream_if.sv
// knn_stream_if: valid/ready channel carrying a generic payload
// depends on nothing
interface knn_stream_if #(
  parameter int unsigned Width = 8
);
  logic             valid;
  logic             ready;
  logic [Width-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/knn_front.sv
// knn_front: accepts input items and queues them for the search engine
// depends on nothing
module knn_front #(
  parameter int unsigned Width = 43,
  parameter int unsigned Depth = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [Width-1:0] in_data,
  output logic             q_valid,
  input  logic             q_ready,
  output logic [Width-1:0] q_data
);
  localparam int unsigned PtrBits = (Depth > 1) ? $clog2(Depth) : 1;

  logic [Width-1:0] slots [Depth];
  logic [PtrBits-1:0] wr_ptr;
  logic [PtrBits-1:0] rd_ptr;
  logic [PtrBits:0] fill;
  logic push;
  logic pop;

  assign in_ready = (fill != Depth[PtrBits:0]);
  assign q_valid  = (fill != '0);
  assign q_data   = slots[rd_ptr];
  assign push = in_valid && in_ready;
  assign pop  = q_valid && q_ready;

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_data;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrBits'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrBits'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      fill <= fill + {{PtrBits{1'b0}}, push} - {{PtrBits{1'b0}}, pop};
    end
  end

  queue_bound_a: assert property (@(posedge clk) disable iff (rst)
    fill <= Depth[PtrBits:0]) else $error("queue overfilled");
  no_pop_empty_a: assert property (@(posedge clk) disable iff (rst)
    (fill == '0) |-> !pop) else $error("pop from empty queue");
  fill_track_a: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (fill == $past(fill) + 1'b1)) else $error("fill count slip");
endmodule

// File: rtl/core/knn_back.sv
// knn_back: point store, distance scan with sorted insertion list, result emission
// depends on knn_pkg
module knn_back #(
  parameter int unsigned MaxPoints = 1024,
  parameter int unsigned MaxNeighbors = 16,
  parameter int unsigned CoordBits = 16,
  parameter int unsigned IdxBits = 10,
  parameter int unsigned PcBits = 11,
  parameter int unsigned NcBits = 5
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  output logic                q_ready,
  input  logic                q_op,
  input  logic [IdxBits-1:0]  q_index,
  input  logic [CoordBits-1:0] q_x,
  input  logic [CoordBits-1:0] q_y,
  input  logic [NcBits-1:0]   neighbor_count,
  input  logic [PcBits-1:0]   point_count,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [IdxBits-1:0]  out_index,
  output logic [3:0]          out_rank,
  output logic                out_last,
  output logic                out_status
);
  localparam int unsigned AddrBits = $clog2(MaxPoints);
  localparam int unsigned DistBits = 2 * CoordBits + 1;
  localparam int unsigned DiffBits = CoordBits + 1;
  localparam int unsigned SlotBits = (MaxNeighbors > 1) ? $clog2(MaxNeighbors) : 1;
  localparam int unsigned CntBits = $clog2(MaxNeighbors + 1);
  localparam int unsigned ScanBits = AddrBits + 1;

  knn_pkg::back_state_t state, state_next;

  logic [2*CoordBits-1:0] store [MaxPoints];
  logic [2*CoordBits-1:0] rd_data;
  logic [AddrBits-1:0] rd_addr;

  logic signed [CoordBits-1:0] qx, qy;
  logic [ScanBits-1:0] scan_cnt;   // addresses issued
  logic [CntBits-1:0] k_eff;
  logic [ScanBits-1:0] n_eff;

  // pipeline: stage a = read data valid, stage b = squares, stage c = distance
  logic v_a, v_b, v_c;
  logic [AddrBits-1:0] idx_a, idx_b, idx_c;
  logic [2*CoordBits-1:0] sqx_b, sqy_b;
  logic [DistBits-1:0] dist_c;
  logic signed [DiffBits-1:0] dx, dy;
  logic [DiffBits-1:0] ax, ay;

  logic [DistBits-1:0] best_d [MaxNeighbors];
  logic [AddrBits-1:0] best_i [MaxNeighbors];
  logic [CntBits-1:0] filled;
  logic [CntBits-1:0] emit_cnt;
  logic err_mode;

  logic [MaxNeighbors-1:0] farther;
  logic q_take;

  // saturated configuration
  always_comb begin
    k_eff = (neighbor_count > NcBits'(MaxNeighbors)) ? CntBits'(MaxNeighbors)
                                                     : CntBits'(neighbor_count);
    n_eff = (point_count > PcBits'(MaxPoints)) ? ScanBits'(MaxPoints)
                                               : ScanBits'(point_count);
  end

  assign q_ready = (state == knn_pkg::ST_IDLE);
  assign q_take  = q_valid && q_ready;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      knn_pkg::ST_IDLE: begin
        if (q_take && q_op == knn_pkg::OP_QUERY && k_eff != '0) begin
          state_next = (ScanBits'(k_eff) > n_eff) ? knn_pkg::ST_EMIT : knn_pkg::ST_SCAN;
        end
      end
      knn_pkg::ST_SCAN: begin
        if (scan_cnt == n_eff - 1'b1) state_next = knn_pkg::ST_DRAIN;
      end
      knn_pkg::ST_DRAIN: begin
        if (!v_a && !v_b && !v_c) state_next = knn_pkg::ST_EMIT;
      end
      knn_pkg::ST_EMIT: begin
        if (out_ready && out_last) state_next = knn_pkg::ST_IDLE;
      end
      default: state_next = knn_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    out_valid  = (state == knn_pkg::ST_EMIT);
    out_status = err_mode;
    out_index  = err_mode ? '0 : IdxBits'(best_i[emit_cnt[SlotBits-1:0]]);
    out_rank   = err_mode ? '0 : 4'(emit_cnt);
    out_last   = err_mode || (emit_cnt == filled - 1'b1);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= knn_pkg::ST_IDLE;
    else state <= state_next;
  end

  // point store
  assign rd_addr = scan_cnt[AddrBits-1:0];
  always_ff @(posedge clk) begin
    if (q_take && q_op == knn_pkg::OP_LOAD && ScanBits'(q_index) < ScanBits'(MaxPoints)) begin
      store[q_index[AddrBits-1:0]] <= {q_x, q_y};
    end
    rd_data <= store[rd_addr];
  end

  // query capture and scan address
  always_ff @(posedge clk) begin
    if (q_take) begin
      qx <= q_x;
      qy <= q_y;
    end
    if (rst) begin
      scan_cnt <= '0;
      err_mode <= 1'b0;
    end else if (q_take) begin
      scan_cnt <= '0;
      err_mode <= (ScanBits'(k_eff) > n_eff);
    end else if (state == knn_pkg::ST_SCAN) begin
      scan_cnt <= scan_cnt + 1'b1;
    end
  end

  // distance pipeline
  always_comb begin
    dx = DiffBits'(qx) - DiffBits'($signed(rd_data[2*CoordBits-1:CoordBits]));
    dy = DiffBits'(qy) - DiffBits'($signed(rd_data[CoordBits-1:0]));
    ax = dx[DiffBits-1] ? DiffBits'(-dx) : DiffBits'(dx);
    ay = dy[DiffBits-1] ? DiffBits'(-dy) : DiffBits'(dy);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_a <= 1'b0;
      v_b <= 1'b0;
      v_c <= 1'b0;
    end else begin
      v_a <= (state == knn_pkg::ST_SCAN);
      v_b <= v_a;
      v_c <= v_b;
    end
    idx_a  <= rd_addr;
    idx_b  <= idx_a;
    idx_c  <= idx_b;
    sqx_b  <= (2*CoordBits)'(ax * ax);
    sqy_b  <= (2*CoordBits)'(ay * ay);
    dist_c <= DistBits'(sqx_b) + DistBits'(sqy_b);
  end

  // insertion into sorted best list: strict compare keeps lower index first on ties
  always_comb begin
    for (int s = 0; s < MaxNeighbors; s++) begin
      farther[s] = (CntBits'(s) >= filled) || (dist_c < best_d[s]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filled <= '0;
    end else if (q_take) begin
      filled <= '0;
    end else if (v_c && filled < k_eff) begin
      filled <= filled + 1'b1;
    end
    if (v_c) begin
      for (int s = 0; s < MaxNeighbors; s++) begin
        if (CntBits'(s) < k_eff && farther[s]) begin
          if (s == 0 || !farther[(s == 0) ? 0 : s-1]) begin
            best_d[s] <= dist_c;
            best_i[s] <= idx_c;
          end else begin
            best_d[s] <= best_d[(s == 0) ? 0 : s-1];
            best_i[s] <= best_i[(s == 0) ? 0 : s-1];
          end
        end
      end
    end
  end

  // emission counter
  always_ff @(posedge clk) begin
    if (rst || q_take) begin
      emit_cnt <= '0;
    end else if (out_valid && out_ready) begin
      emit_cnt <= emit_cnt + 1'b1;
    end
  end

  no_take_busy_a: assert property (@(posedge clk) disable iff (rst)
    (state != knn_pkg::ST_IDLE) |-> !q_take) else $error("item taken while busy");
  fill_bound_a: assert property (@(posedge clk) disable iff (rst)
    filled <= k_eff || state == knn_pkg::ST_IDLE) else $error("best list overfilled");
  emit_bound_a: assert property (@(posedge clk) disable iff (rst)
    (state == knn_pkg::ST_EMIT && !err_mode) |-> (emit_cnt < filled))
    else $error("emit past list");
  drain_done_a: assert property (@(posedge clk) disable iff (rst)
    (state == knn_pkg::ST_EMIT) |-> !v_c) else $error("emit before scan drained");
endmodule

// File: rtl/core/k_nearest_neighbor_search.sv
// k_nearest_neighbor_search: brute-force 2d k nearest neighbours over a point store
// a query's results are emitted once its scan and the distance pipeline have drained,
// one result a cycle while out_ready is high; the back end takes no new item until the
// last result is accepted; the scan reads one stored point per cycle from the single read port
// reset clears control and registers (neighbor_count 1, point_count 1); the store is not cleared
module k_nearest_neighbor_search #(
  parameter int unsigned MAX_POINTS = 1024,
  parameter int unsigned MAX_NEIGHBORS = 16,
  parameter int unsigned COORD_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  knn_stream_if.sink   in_ch,
  knn_stream_if.source out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int unsigned InWidth = 1 + 10 + 2 * COORD_BITS;

  logic [4:0]  neighbor_count;
  logic [10:0] point_count;
  logic        q_valid, q_ready;
  logic [InWidth-1:0] q_data;
  logic        wr_en;
  knn_pkg::reg_idx_t reg_sel;

  // configuration registers
  assign pready  = 1'b1;
  assign reg_sel = knn_pkg::reg_idx_t'(paddr[2]);
  assign wr_en   = psel && penable && pwrite && (paddr[1:0] == 2'b00);
  always_ff @(posedge clk) begin
    if (rst) begin
      neighbor_count <= 5'd1;
      point_count    <= 11'd1;
    end else if (wr_en) begin
      case (reg_sel)
        knn_pkg::REG_NEIGHBOR_COUNT: neighbor_count <= pwdata[4:0];
        knn_pkg::REG_POINT_COUNT:    point_count <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      knn_pkg::REG_NEIGHBOR_COUNT: prdata = {27'd0, neighbor_count};
      knn_pkg::REG_POINT_COUNT:    prdata = {21'd0, point_count};
      default: prdata = '0;
    endcase
  end

  knn_front #(.Width(InWidth), .Depth(2)) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_data  (in_ch.data),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_data   (q_data)
  );

  knn_back #(
    .MaxPoints    (MAX_POINTS),
    .MaxNeighbors (MAX_NEIGHBORS),
    .CoordBits    (COORD_BITS),
    .IdxBits      (10),
    .PcBits       (11),
    .NcBits       (5)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (q_valid),
    .q_ready        (q_ready),
    .q_op           (q_data[InWidth-1]),
    .q_index        (q_data[InWidth-2 -: 10]),
    .q_x            (q_data[2*COORD_BITS-1:COORD_BITS]),
    .q_y            (q_data[COORD_BITS-1:0]),
    .neighbor_count (neighbor_count),
    .point_count    (point_count),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_index      (out_ch.data[15:6]),
    .out_rank       (out_ch.data[5:2]),
    .out_last       (out_ch.data[1]),
    .out_status     (out_ch.data[0])
  );
endmodule

// File: dv/knn_tb_if.sv
// knn_tb_if: no extra interface is needed, the channels reuse knn_stream_if
// depends on nothing
package knn_tb_pkg;

  // one result item as the block reports it
  typedef struct packed {
    logic [9:0] neighbor_index;
    logic [3:0] rank;
    logic       last;
    logic       status;
  } neighbor_t;
endpackage

// File: dv/tb_top.sv
// tb_top: self-checking bench for k_nearest_neighbor_search
// drives load and query items, predicts neighbour lists, checks every result item
// depends on knn_pkg, knn_stream_if and knn_tb_pkg
module tb_top;

  localparam int NumPoints = 1024;
  localparam int NumBest = 16;
  localparam int CycleLimit = 1000000;
  localparam int SettleCycles = 1100;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  knn_stream_if #(.Width(43)) in_ch ();
  knn_stream_if #(.Width(16)) out_ch ();

  k_nearest_neighbor_search DUT (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // shadow of the block state
  logic signed [15:0] shadow_x [NumPoints];
  logic signed [15:0] shadow_y [NumPoints];
  logic [4:0]  shadow_k;
  logic [10:0] shadow_n;
  int filled_upto;   // slots 0..filled_upto-1 are known written

  knn_tb_pkg::neighbor_t pending_neighbours [$];
  int errors;
  int cycles;
  int queries_sent;
  int loads_sent;
  int results_seen;
  int burst_left;
  bit stall_mode;

  // clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // cycle counter and timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("%0t timeout with %0d results outstanding", $time, pending_neighbours.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // work out the neighbour list of one query
  task automatic predict_query(input logic signed [15:0] qx, input logic signed [15:0] qy);
    longint unsigned best_d [NumBest];
    int best_i [NumBest];
    int k;
    int n;
    int filled;
    int pos;
    int t;
    longint dx;
    longint dy;
    longint unsigned d;
    knn_tb_pkg::neighbor_t res;
    k = (shadow_k > NumBest) ? NumBest : int'(shadow_k);
    n = (shadow_n > NumPoints) ? NumPoints : int'(shadow_n);
    filled = 0;
    if (k == 0) return;
    if (k > n) begin
      res = '{neighbor_index: '0, rank: '0, last: 1'b1, status: 1'b1};
      pending_neighbours.push_back(res);
      return;
    end
    for (int j = 0; j < n; j++) begin
      dx = longint'(qx) - longint'(shadow_x[j]);
      dy = longint'(qy) - longint'(shadow_y[j]);
      d = longint'(dx * dx + dy * dy);
      pos = filled;
      // stay behind every entry that is not farther away
      while (pos > 0 && d < best_d[pos-1]) pos--;
      if (pos >= k) continue;
      t = (filled < k) ? filled : k - 1;
      while (t > pos) begin
        best_d[t] = best_d[t-1];
        best_i[t] = best_i[t-1];
        t--;
      end
      best_d[pos] = d;
      best_i[pos] = j;
      if (filled < k) filled++;
    end
    for (int r = 0; r < filled; r++) begin
      res.neighbor_index = best_i[r][9:0];
      res.rank = r[3:0];
      res.last = (r + 1 == filled);
      res.status = 1'b0;
      pending_neighbours.push_back(res);
    end
  endtask

  // send one item, in bursts with random gaps
  task automatic send_item(input knn_pkg::op_t op, input logic [9:0] idx,
                           input logic signed [15:0] x, input logic signed [15:0] y);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.data <= {op, idx, x, y};
    do @(posedge clk); while (!in_ch.ready);
    if (op == knn_pkg::OP_LOAD) begin
      shadow_x[idx] = x;
      shadow_y[idx] = y;
      loads_sent++;
    end else begin
      predict_query(x, y);
      queries_sent++;
    end
  endtask

  task automatic stop_sending();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    burst_left = 0;
  endtask

  // wait for all results, then for an idle scan to finish
  task automatic drain_all();
    stop_sending();
    while (pending_neighbours.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // apb write, only called while the block is idle
  task automatic reg_write(input knn_pkg::reg_idx_t which, input logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {which, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (which == knn_pkg::REG_NEIGHBOR_COUNT) shadow_k = value[4:0];
    else shadow_n = value[10:0];
  endtask

  task automatic set_counts(input int k, input int n);
    drain_all();
    reg_write(knn_pkg::REG_NEIGHBOR_COUNT, k);
    reg_write(knn_pkg::REG_POINT_COUNT, n);
  endtask

  // receiver stalls at random in two modes: rare stalls or frequent stalls
  always @(negedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if ($urandom_range(0, 63) == 0) stall_mode = !stall_mode;
      if (stall_mode) out_ch.ready <= ($urandom_range(0, 2) != 0);
      else out_ch.ready <= ($urandom_range(0, 15) != 0);
    end
  end

  // check each result item against the oldest expectation
  always @(posedge clk) begin
    knn_tb_pkg::neighbor_t got;
    knn_tb_pkg::neighbor_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      results_seen++;
      if (pending_neighbours.size() == 0) begin
        $display("%0t unexpected result: got %p", $time, got);
        errors++;
      end else begin
        want = pending_neighbours.pop_front();
        if (got.neighbor_index !== want.neighbor_index)
          $display("%0t neighbor_index: expected %0d actual %0d", $time,
                   want.neighbor_index, got.neighbor_index);
        if (got.rank !== want.rank)
          $display("%0t rank: expected %0d actual %0d", $time, want.rank, got.rank);
        if (got.last !== want.last)
          $display("%0t last: expected %0b actual %0b", $time, want.last, got.last);
        if (got.status !== want.status)
          $display("%0t status: expected %0b actual %0b", $time, want.status, got.status);
        if (got !== want) errors++;
      end
    end
  end

  // defaults after reset: one neighbour among one point
  task automatic test_reset_defaults();
    send_item(knn_pkg::OP_LOAD, 10'd0, 16'sd5, -16'sd7);
    send_item(knn_pkg::OP_QUERY, 10'd0, 16'sd0, 16'sd0);
    send_item(knn_pkg::OP_QUERY, 10'h3ff, 16'sh7fff, 16'sh8000);
    filled_upto = 1;
  endtask

  // extremes, ties and the error and empty cases on sixteen points
  task automatic test_directed();
    send_item(knn_pkg::OP_LOAD, 10'd0, 16'sh8000, 16'sh8000);
    send_item(knn_pkg::OP_LOAD, 10'd1, 16'sh7fff, 16'sh7fff);
    send_item(knn_pkg::OP_LOAD, 10'd2, 16'sd100, 16'sd100);
    send_item(knn_pkg::OP_LOAD, 10'd3, 16'sd100, 16'sd100);
    for (int i = 4; i < 16; i++)
      send_item(knn_pkg::OP_LOAD, i[9:0], 16'(i * 37 - 300), 16'(300 - i * 41));
    filled_upto = 16;
    set_counts(4, 16);
    send_item(knn_pkg::OP_QUERY, 10'd0, 16'sh7fff, 16'sh7fff);
    send_item(knn_pkg::OP_QUERY, 10'd0, 16'sh8000, 16'sh8000);
    send_item(knn_pkg::OP_QUERY, 10'd0, 16'sh7fff, 16'sh8000);
    send_item(knn_pkg::OP_QUERY, 10'd0, 16'sd100, 16'sd100);
    // no neighbours asked for
    set_counts(0, 16);
    send_item(knn_pkg::OP_QUERY, 10'd0, 16'sd1, 16'sd1);
    // saturated neighbour count over all sixteen points
    set_counts(31, 16);
    send_item(knn_pkg::OP_QUERY, 10'd0, 16'sd0, 16'sd0);
    // too many neighbours
    set_counts(5, 0);
    send_item(knn_pkg::OP_QUERY, 10'd0, 16'sd0, 16'sd0);
    set_counts(16, 15);
    send_item(knn_pkg::OP_QUERY, 10'd0, 16'sd0, 16'sd0);
  endtask

  // fill the first 64 slots, then query over all of them
  task automatic test_many_points();
    for (int i = 16; i < 64; i++)
      send_item(knn_pkg::OP_LOAD, i[9:0], 16'($urandom), 16'($urandom));
    filled_upto = 64;
    set_counts(16, 64);
    send_item(knn_pkg::OP_QUERY, 10'd0, 16'($urandom), 16'($urandom));
    send_item(knn_pkg::OP_QUERY, 10'd0, 16'sh8000, 16'sh7fff);
    set_counts(1, 64);
    send_item(knn_pkg::OP_QUERY, 10'd0, 16'sd0, 16'sd0);
  endtask

  // random configurations over the written slots, with mixed load and query items
  task automatic test_random();
    int k;
    int n;
    logic [9:0] slot;
    for (int i = 0; i < 180; i++) begin
      if (i % 18 == 0) begin
        k = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 16);
        case ($urandom_range(0, 9))
          0: n = filled_upto;
          1: n = $urandom_range(0, filled_upto);
          default: n = $urandom_range(1, filled_upto);
        endcase
        set_counts(k, n);
      end
      if (i == 90) begin
        // hold off until the block has caught up
        stop_sending();
        while (pending_neighbours.size() != 0) @(posedge clk);
      end
      if ($urandom_range(0, 9) < 6) begin
        send_item(knn_pkg::OP_QUERY, 10'($urandom), 16'($urandom), 16'($urandom));
      end else begin
        // near duplicates of the first slots make ties likely
        slot = ($urandom_range(0, 1) != 0) ? 10'($urandom_range(0, 63)) : 10'($urandom);
        if ($urandom_range(0, 3) == 0)
          send_item(knn_pkg::OP_LOAD, slot, shadow_x[$urandom_range(0, 63)],
                    shadow_y[$urandom_range(0, 63)]);
        else
          send_item(knn_pkg::OP_LOAD, slot, 16'($urandom), 16'($urandom));
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    shadow_k = 5'd1;
    shadow_n = 11'd1;
    errors = 0;
    queries_sent = 0;
    loads_sent = 0;
    results_seen = 0;
    burst_left = 0;
    stall_mode = 1'b0;
    filled_upto = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_directed();
    test_many_points();
    test_random();
    drain_all();

    $display("covered %0d loads and %0d queries, %0d result items checked",
             loads_sent, queries_sent, results_seen);
    $display("neighbour counts 0 to 31 and point counts 0 to 64, ties and error cases");
    if (errors == 0 && pending_neighbours.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

// File: k_nearest_neighbor_search.f
rtl/core/knn_pkg.sv
rtl/core/knn_stream_if.sv
rtl/core/knn_front.sv
rtl/core/knn_back.sv
rtl/core/k_nearest_neighbor_search.sv
dv/knn_tb_if.sv
dv/tb_top.sv
